// File: rtl/ywb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ywb_pkg
// Shared widths, constants, register codes and pipeline types of the
// watermark pixel blend.
// ----------------------------------------------------------------------------
package ywb_pkg;

  // sample and arithmetic widths
  localparam int PIX_W          = 8;
  localparam int TOP_W          = 9;
  localparam int SQ_W           = 2 * TOP_W;
  localparam int FRAC_W         = 16;
  localparam int RATIO_W        = FRAC_W + 1;
  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = FRAC_W / BITS_PER_STAGE;

  // stream and configuration port widths
  localparam int IN_DATA_W  = 6 * PIX_W;
  localparam int OUT_DATA_W = 3 * PIX_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TOP_W;

  // fixed levels; white mode divides by 40000, which is 200 squared
  localparam logic [PIX_W-1:0]   WHITE_SKIP     = 8'd40;
  localparam logic [TOP_W-1:0]   WHITE_TOP      = 9'd200;
  localparam logic [PIX_W-1:0]   WHITE_LUMA     = 8'd255;
  localparam logic [PIX_W-1:0]   NEUTRAL_CHROMA = 8'd128;
  localparam logic [RATIO_W-1:0] RATIO_ONE      = 17'h10000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WHITE_MODE   = 2'd0,
    CFG_NEUTRAL_SKIP = 2'd1,
    CFG_CHROMA_SKIP  = 2'd2,
    CFG_TOP_LEVEL    = 2'd3
  } cfg_idx_t;

  // configuration register file
  typedef struct packed {
    logic              white_mode;
    logic [PIX_W-1:0]  neutral_skip;
    logic [PIX_W-1:0]  chroma_skip;
    logic [TOP_W-1:0]  top_level;
  } cfg_t;

  // per-pixel payload that travels down the pipeline
  typedef struct packed {
    logic [PIX_W-1:0] src_y;
    logic [PIX_W-1:0] src_cb;
    logic [PIX_W-1:0] src_cr;
    logic [PIX_W-1:0] tgt_y;
    logic [PIX_W-1:0] tgt_cb;
    logic [PIX_W-1:0] tgt_cr;
    logic             keep;   // pass source through, no blend
    logic             full;   // ratio saturates at one
  } pix_t;

  // distance of a chroma sample from neutral
  function automatic logic [PIX_W-1:0] abs_off(input logic [PIX_W-1:0] v);
    return (v >= NEUTRAL_CHROMA) ? PIX_W'(v - NEUTRAL_CHROMA) : PIX_W'(NEUTRAL_CHROMA - v);
  endfunction

endpackage

// File: rtl/ywb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ywb_front
// Pixel decode (skip decision, target, strength) and squaring of strength
// and top level, two register stages.
// ----------------------------------------------------------------------------
module ywb_front import ywb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [IN_DATA_W-1:0] up_data,
  input  logic                 up_blank,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output pix_t                 dn_pix,
  output logic [SQ_W-1:0]      dn_num,
  output logic [SQ_W-1:0]      dn_den
);

  logic [PIX_W-1:0] sy, su, sv, my, mu, mv;
  logic [TOP_W-1:0] d;
  logic             skip;
  pix_t             pix1_nxt;
  logic [TOP_W-1:0] s1_nxt, t1_nxt;

  logic             v1_r, v2_r;
  pix_t             pix1_r, pix2_r;
  logic [TOP_W-1:0] s1_r, t1_r;
  logic [SQ_W-1:0]  num2_r, den2_r;
  logic             rdy1, rdy2;

  // unpack input samples
  assign sy = up_data[0*PIX_W +: PIX_W];
  assign su = up_data[1*PIX_W +: PIX_W];
  assign sv = up_data[2*PIX_W +: PIX_W];
  assign my = up_data[3*PIX_W +: PIX_W];
  assign mu = up_data[4*PIX_W +: PIX_W];
  assign mv = up_data[5*PIX_W +: PIX_W];

  // decode: target, strength, top and skip
  always_comb begin
    d = TOP_W'(abs_off(mu)) + TOP_W'(abs_off(mv));
    pix1_nxt.src_y  = sy;
    pix1_nxt.src_cb = su;
    pix1_nxt.src_cr = sv;
    if (cfg.white_mode) begin
      s1_nxt          = TOP_W'(my);
      t1_nxt          = WHITE_TOP;
      skip            = (my <= WHITE_SKIP);
      pix1_nxt.tgt_y  = WHITE_LUMA;
      pix1_nxt.tgt_cb = NEUTRAL_CHROMA;
      pix1_nxt.tgt_cr = NEUTRAL_CHROMA;
    end else begin
      s1_nxt          = TOP_W'(my) + d;
      t1_nxt          = cfg.top_level;
      skip            = (d == '0) ? (my <= cfg.neutral_skip) : (my <= cfg.chroma_skip);
      pix1_nxt.tgt_y  = my;
      pix1_nxt.tgt_cb = mu;
      pix1_nxt.tgt_cr = mv;
    end
    pix1_nxt.keep = up_blank | skip;
    pix1_nxt.full = (t1_nxt == '0) || (s1_nxt >= t1_nxt);
  end

  // stage ready chain
  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= up_valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      pix1_r <= pix1_nxt;
      s1_r   <= s1_nxt;
      t1_r   <= t1_nxt;
    end
  end

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  // stage 2 payload: squares of strength and top
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      pix2_r <= pix1_r;
      num2_r <= SQ_W'(s1_r) * SQ_W'(s1_r);
      den2_r <= SQ_W'(t1_r) * SQ_W'(t1_r);
    end
  end

  assign dn_valid = v2_r;
  assign dn_pix   = pix2_r;
  assign dn_num   = num2_r;
  assign dn_den   = den2_r;

endmodule

// File: rtl/ywb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ywb_div
// Pipelined restoring divider for the blend ratio: two quotient bits per
// stage, sixteen fraction bits in all, saturated to one at the output.
// ----------------------------------------------------------------------------
module ywb_div import ywb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  pix_t               up_pix,
  input  logic [SQ_W-1:0]    up_num,
  input  logic [SQ_W-1:0]    up_den,
  output logic               dn_valid,
  input  logic               dn_ready,
  output pix_t               dn_pix,
  output logic [RATIO_W-1:0] dn_ratio
);

  localparam int LAST = DIV_STAGES - 1;

  logic              v_r   [DIV_STAGES];
  pix_t              pix_r [DIV_STAGES];
  logic [SQ_W-1:0]   rem_r [DIV_STAGES];
  logic [SQ_W-1:0]   den_r [DIV_STAGES];
  logic [FRAC_W-1:0] q_r   [DIV_STAGES];
  logic              rdy   [DIV_STAGES+1];

  assign rdy[DIV_STAGES] = dn_ready;
  assign up_ready        = rdy[0];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic              in_v;
    pix_t              in_pix;
    logic [SQ_W-1:0]   in_rem;
    logic [SQ_W-1:0]   in_den;
    logic [FRAC_W-1:0] in_q;
    logic [SQ_W-1:0]   rem_nxt;
    logic [FRAC_W-1:0] q_nxt;
    logic [SQ_W:0]     wide;

    // stage input: from the front or from the previous stage
    if (k == 0) begin : g_head
      assign in_v   = up_valid;
      assign in_pix = up_pix;
      assign in_rem = up_num;
      assign in_den = up_den;
      assign in_q   = '0;
    end else begin : g_body
      assign in_v   = v_r[k-1];
      assign in_pix = pix_r[k-1];
      assign in_rem = rem_r[k-1];
      assign in_den = den_r[k-1];
      assign in_q   = q_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    // shift, compare and subtract for each quotient bit of the stage
    always_comb begin
      rem_nxt = in_rem;
      q_nxt   = in_q;
      wide    = '0;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        wide = {rem_nxt, 1'b0};
        if (wide >= {1'b0, in_den}) begin
          rem_nxt = SQ_W'(wide - {1'b0, in_den});
          q_nxt   = {q_nxt[FRAC_W-2:0], 1'b1};
        end else begin
          rem_nxt = wide[SQ_W-1:0];
          q_nxt   = {q_nxt[FRAC_W-2:0], 1'b0};
        end
      end
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= in_v;
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (rdy[k] && in_v) begin
        pix_r[k] <= in_pix;
        rem_r[k] <= rem_nxt;
        den_r[k] <= in_den;
        q_r[k]   <= q_nxt;
      end
    end
  end

  // saturate when strength reaches the top level or the top level is zero
  assign dn_valid = v_r[LAST];
  assign dn_pix   = pix_r[LAST];
  assign dn_ratio = pix_r[LAST].full ? RATIO_ONE : {1'b0, q_r[LAST]};

`ifndef SYNTHESIS
  // remainder stays below divisor when the quotient is used
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] && !pix_r[LAST].full |-> rem_r[LAST] < den_r[LAST])
    else $error("divider remainder not below divisor");

  // a stalled result stays in the last stage
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] && !dn_ready |=> v_r[LAST])
    else $error("divider result lost under stall");
`endif

endmodule

// File: rtl/ywb_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ywb_mix
// Moves each component toward its target by the ratio, or passes the source
// through for kept pixels, and holds the result in the output register.
// ----------------------------------------------------------------------------
module ywb_mix import ywb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  pix_t                  up_pix,
  input  logic [RATIO_W-1:0]    up_ratio,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int PROD_W = PIX_W + RATIO_W;

  logic                  vo_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic                  blend_r;
  logic [OUT_DATA_W-1:0] data_nxt;

  // one component: step truncated toward zero, then toward the target
  function automatic logic [PIX_W-1:0] move_toward(input logic [PIX_W-1:0]   src,
                                                   input logic [PIX_W-1:0]   tgt,
                                                   input logic [RATIO_W-1:0] ratio);
    logic              up;
    logic [PIX_W-1:0]  diff;
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  stp;
    up   = (tgt >= src);
    diff = up ? PIX_W'(tgt - src) : PIX_W'(src - tgt);
    prod = PROD_W'(diff) * PROD_W'(ratio);
    stp  = prod[FRAC_W +: PIX_W];
    return up ? PIX_W'(src + stp) : PIX_W'(src - stp);
  endfunction

  // blended or passed-through samples
  always_comb begin
    if (up_pix.keep) begin
      data_nxt = {up_pix.src_cr, up_pix.src_cb, up_pix.src_y};
    end else begin
      data_nxt = {move_toward(up_pix.src_cr, up_pix.tgt_cr, up_ratio),
                  move_toward(up_pix.src_cb, up_pix.tgt_cb, up_ratio),
                  move_toward(up_pix.src_y,  up_pix.tgt_y,  up_ratio)};
    end
  end

  assign up_ready = !vo_r || out_tready;

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (up_ready) begin
      vo_r <= up_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r  <= data_nxt;
      blend_r <= !up_pix.keep;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = data_r;
  assign out_tuser  = blend_r;

endmodule

// File: rtl/yuv_watermark_pixel_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv_watermark_pixel_blend
// Watermark blend of YUV 4:2:0 pixels toward the watermark colour or white.
//
//   channel  direction  handshake             payload
//   in_      slave      in_tvalid/in_tready   tdata: source and mark samples
//                                             tuser: blank watermark row
//   out_     master     out_tvalid/out_tready tdata: blended samples
//                                             tuser: blended flag
//   cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One pixel per clock sustained while out_tready stays high; eleven register stages
// from input transfer to out_tvalid: decode, squaring, eight two-bit divider stages, blend.
// rst_n (synchronous) empties the pipeline and clears the configuration to 0.
// Each stage loads when it is empty or the stage after it moves, so bubbles
// close up under a stall and in_tready stays high until the whole pipeline
// is full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module yuv_watermark_pixel_blend import ywb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // src_luma, src_cb, src_cr, mark_luma, mark_cb, mark_cr
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // row_blank
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_luma, out_cb, out_cr
  output logic [OUT_DATA_W-1:0] out_tdata,
  // blended
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t               cfg_r;
  logic               f_valid, f_ready;
  pix_t               f_pix;
  logic [SQ_W-1:0]    f_num, f_den;
  logic               d_valid, d_ready;
  pix_t               d_pix;
  logic [RATIO_W-1:0] d_ratio;

  assign cfg_ready = 1'b1;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WHITE_MODE:   cfg_r.white_mode   <= cfg_data[0];
        CFG_NEUTRAL_SKIP: cfg_r.neutral_skip <= cfg_data[PIX_W-1:0];
        CFG_CHROMA_SKIP:  cfg_r.chroma_skip  <= cfg_data[PIX_W-1:0];
        CFG_TOP_LEVEL:    cfg_r.top_level    <= cfg_data[TOP_W-1:0];
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  // decode and squaring
  ywb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  (in_tdata),
    .up_blank (in_tuser),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_pix   (f_pix),
    .dn_num   (f_num),
    .dn_den   (f_den)
  );

  // ratio divider
  ywb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_pix   (f_pix),
    .up_num   (f_num),
    .up_den   (f_den),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_pix   (d_pix),
    .dn_ratio (d_ratio)
  );

  // blend and output register
  ywb_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (d_valid),
    .up_ready   (d_ready),
    .up_pix     (d_pix),
    .up_ratio   (d_ratio),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // input back-pressure only when the output is holding a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output is free");
`endif

endmodule

// File: bench/tb_yuv_watermark_pixel_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuv_watermark_pixel_blend
// Self-checking bench for the watermark pixel blend. A short directed list
// walks every skip rule, blank rows, zero top, white mode and the sample
// extremes. Random pixels then run under several register settings, with
// random back-pressure on both streams. A predictor computes each blended
// pixel, and every output transfer is compared field by field.
// ----------------------------------------------------------------------------
module tb_yuv_watermark_pixel_blend import ywb_pkg::*; ();

  localparam longint WHITE_DIVISOR = 40000;
  localparam int     DIR_ROWS      = 22;
  localparam int     RAND_BLOCKS   = 12;
  localparam int     BLOCK_PIXELS  = 150;

  typedef struct packed {
    logic [7:0] src_y, src_cb, src_cr;
    logic [7:0] mark_y, mark_cb, mark_cr;
    logic       blank;
  } pixel_t;

  typedef struct packed {
    logic [7:0] y, cb, cr;
    logic       blended;
  } result_t;

  // directed row: register set, pixel, and a typed result where obvious
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] sy, su, sv, my, mu, mv;
    logic       blank;
    logic       typed;
    logic [7:0] ey, eu, ev;
    logic       eb;
  } dir_row_t;

  // register sets: white_mode, neutral_skip, chroma_skip, top_level
  localparam cfg_t DIR_MODES [0:5] = '{
    '{1'b0, 8'd0,   8'd0,   9'd0},
    '{1'b0, 8'd100, 8'd50,  9'd511},
    '{1'b1, 8'd255, 8'd255, 9'd1},
    '{1'b0, 8'd255, 8'd255, 9'd1},
    '{1'b0, 8'd0,   8'd0,   9'd1},
    '{1'b0, 8'd0,   8'd0,   9'd300}
  };

  localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
    // mode  source        mark          blank typed  expected
    '{0,  10,  20,  30,  200,  50,  60,  0, 1,  200,  50,  60, 1}, // zero top, full
    '{0,  10,  20,  30,  200,  50,  60,  1, 1,   10,  20,  30, 0}, // blank row
    '{0, 255, 255, 255,    0, 128, 128,  0, 1,  255, 255, 255, 0}, // neutral skip at 0
    '{0,   0,   0,   0,  255, 255, 255,  0, 1,  255, 255, 255, 1},
    '{0, 255,   0, 255,    1,   0, 255,  0, 1,    1,   0, 255, 1},
    '{1,  30, 200,  60,  100, 128, 128,  0, 1,   30, 200,  60, 0}, // neutral skip edge
    '{1,  30, 200,  60,  101, 128, 128,  0, 0,    0,   0,   0, 0},
    '{1, 170,  85,  90,   50,   0, 255,  0, 1,  170,  85,  90, 0}, // chroma skip edge
    '{1, 170,  85,  90,   51,   0,   0,  0, 0,    0,   0,   0, 0},
    '{1,   0, 255,   0,  255, 255,   0,  0, 0,    0,   0,   0, 0},
    '{2,  90,  10, 240,   40,   0,   0,  0, 1,   90,  10, 240, 0}, // white skip edge
    '{2,  90,  10, 240,   41,   0,   0,  0, 0,    0,   0,   0, 0},
    '{2,  90,  10, 240,  200,   3,   7,  0, 1,  255, 128, 128, 1}, // ratio exactly one
    '{2,   0,   0, 255,  255, 255, 255,  0, 1,  255, 128, 128, 1},
    '{2,   0,   0, 255,  255, 255, 255,  1, 1,    0,   0, 255, 0},
    '{2, 200, 100, 150,  120,  60,  60,  0, 0,    0,   0,   0, 0},
    '{3,  12,  34,  56,  255, 128, 128,  0, 1,   12,  34,  56, 0},
    '{3,  12,  34,  56,  255,   0, 128,  0, 1,   12,  34,  56, 0},
    '{4,  77,  88,  99,    0, 129, 128,  0, 1,   77,  88,  99, 0},
    '{4,  77,  88,  99,    1, 128, 128,  0, 1,    1, 128, 128, 1},
    '{5,  10, 240,  20,  128,  60, 200,  0, 0,    0,   0,   0, 0},
    '{5, 255, 255, 255,  255,   0,   0,  0, 0,    0,   0,   0, 0}
  };

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index  = CFG_WHITE_MODE;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  cfg_t    active_cfg   = '0;
  result_t due_pixels [$];
  int      mismatches   = 0;
  int      src_idle_pct = 0;
  int      snk_idle_pct = 0;
  result_t got_px, want_px;

  yuv_watermark_pixel_blend uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // distance of a chroma sample from neutral grey
  function automatic logic [7:0] chroma_offset(input logic [7:0] v);
    return (v >= NEUTRAL_CHROMA) ? 8'(v - NEUTRAL_CHROMA) : 8'(NEUTRAL_CHROMA - v);
  endfunction

  // move one sample toward its target, step truncated toward zero
  function automatic logic [7:0] step_toward(input logic [7:0] src, input logic [7:0] tgt,
                                             input logic [16:0] ratio);
    logic [24:0] prod;
    if (tgt >= src) begin
      prod = 25'(tgt - src) * ratio;
      return 8'(src + prod[23:16]);
    end
    prod = 25'(src - tgt) * ratio;
    return 8'(src - prod[23:16]);
  endfunction

  // expected output of one pixel under the given registers
  function automatic result_t blend_pixel(input pixel_t p, input cfg_t c);
    logic [8:0]  chroma_dist;
    logic [8:0]  strength;
    logic [7:0]  ty, tcb, tcr;
    logic [63:0] num, den;
    logic [16:0] ratio;
    logic        skip;
    if (c.white_mode) begin
      skip = (p.mark_y <= WHITE_SKIP);
      ty   = WHITE_LUMA;
      tcb  = NEUTRAL_CHROMA;
      tcr  = NEUTRAL_CHROMA;
      num  = 64'(p.mark_y) * p.mark_y * 64'd65536;
      den  = WHITE_DIVISOR;
    end else begin
      chroma_dist = 9'(chroma_offset(p.mark_cb)) + 9'(chroma_offset(p.mark_cr));
      skip        = (chroma_dist == 0) ? (p.mark_y <= c.neutral_skip)
                                       : (p.mark_y <= c.chroma_skip);
      strength    = 9'(p.mark_y) + chroma_dist;
      ty          = p.mark_y;
      tcb         = p.mark_cb;
      tcr         = p.mark_cr;
      num         = 64'(strength) * strength * 64'd65536;
      den         = 64'(c.top_level) * c.top_level;
    end
    // a zero top means full replacement
    if (den == 0 || num / den > 64'(RATIO_ONE))
      ratio = RATIO_ONE;
    else
      ratio = 17'(num / den);
    if (p.blank || skip)
      return '{p.src_y, p.src_cb, p.src_cr, 1'b0};
    return '{step_toward(p.src_y, ty, ratio), step_toward(p.src_cb, tcb, ratio),
             step_toward(p.src_cr, tcr, ratio), 1'b1};
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cfg_t random_cfg(input int blk);
    cfg_t c;
    c.white_mode   = (blk % 3 == 1);
    c.neutral_skip = pick_level();
    c.chroma_skip  = pick_level();
    case ($urandom_range(0, 3))
      0:       c.top_level = 9'd0;
      1:       c.top_level = 9'd511;
      2:       c.top_level = 9'($urandom_range(1, 40));
      default: c.top_level = 9'($urandom_range(1, 511));
    endcase
    return c;
  endfunction

  // random pixel, biased toward neutral marks and the skip edges
  function automatic pixel_t random_pixel(input cfg_t c);
    pixel_t     p;
    logic [7:0] thr;
    p.src_y   = 8'($urandom);
    p.src_cb  = 8'($urandom);
    p.src_cr  = 8'($urandom);
    p.mark_y  = 8'($urandom);
    p.mark_cb = 8'($urandom);
    p.mark_cr = 8'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      p.mark_cb = NEUTRAL_CHROMA;
      p.mark_cr = NEUTRAL_CHROMA;
    end
    p.blank = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 4) == 0) begin
      if (c.white_mode)
        thr = WHITE_SKIP;
      else if (p.mark_cb == NEUTRAL_CHROMA && p.mark_cr == NEUTRAL_CHROMA)
        thr = c.neutral_skip;
      else
        thr = c.chroma_skip;
      p.mark_y = (thr == 8'd255) ? thr : 8'(thr + $urandom_range(0, 1));
    end
    return p;
  endfunction

  // one input transfer, after a random gap
  task automatic send_pixel(input pixel_t p, input result_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p.mark_cr, p.mark_cb, p.mark_y, p.src_cr, p.src_cb, p.src_y};
    in_tuser  <= p.blank;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    due_pixels.push_back(want);
  endtask

  // wait for the pipeline to drain, then write all four registers
  task automatic apply_config(input cfg_t c);
    cfg_idx_t              idx;
    logic [CFG_DATA_W-1:0] val;
    in_tvalid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_t'(i);
      case (idx)
        CFG_WHITE_MODE:   val = CFG_DATA_W'(c.white_mode);
        CFG_NEUTRAL_SKIP: val = CFG_DATA_W'(c.neutral_skip);
        CFG_CHROMA_SKIP:  val = CFG_DATA_W'(c.chroma_skip);
        default:          val = c.top_level;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid  <= 1'b0;
    active_cfg = c;
  endtask

  task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, label, want, got);
      mismatches++;
    end
  endtask

  // output side: random back-pressure and comparison of each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_px = '{out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tuser};
        if (due_pixels.size() == 0) begin
          $display("%0t: unexpected transfer, expected none actual %h/%b",
                   $time, out_tdata, out_tuser);
          mismatches++;
        end else begin
          want_px = due_pixels.pop_front();
          check_field("out_luma", want_px.y, got_px.y);
          check_field("out_cb", want_px.cb, got_px.cb);
          check_field("out_cr", want_px.cr, got_px.cr);
          check_field("blended", 8'(want_px.blended), 8'(got_px.blended));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // stimulus
  initial begin
    dir_row_t row;
    pixel_t   px;
    result_t  want;
    src_idle_pct = 31;
    snk_idle_pct = 56;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED[i];
      if (DIR_MODES[row.mode] != active_cfg)
        apply_config(DIR_MODES[row.mode]);
      px   = '{row.sy, row.su, row.sv, row.my, row.mu, row.mv, row.blank};
      want = row.typed ? result_t'({row.ey, row.eu, row.ev, row.eb})
                       : blend_pixel(px, active_cfg);
      send_pixel(px, want);
    end

    // random blocks, idling shifts from sender-light to receiver-light to none
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      if (blk < 4) begin
        src_idle_pct = 31;
        snk_idle_pct = 56;
      end else if (blk < 8) begin
        src_idle_pct = 56;
        snk_idle_pct = 31;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      apply_config(random_cfg(blk));
      repeat (BLOCK_PIXELS) begin
        px = random_pixel(active_cfg);
        send_pixel(px, blend_pixel(px, active_cfg));
      end
    end

    // drain, then allow for stray transfers
    in_tvalid <= 1'b0;
    while (due_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
